FILE: rtl/mwatc_pkg.sv
// ----------------------------------------------------------------------------
// mwatc_pkg
// Shared types and fixed constants of the sliding window threshold counter.
// ----------------------------------------------------------------------------
package mwatc_pkg;

    localparam int WLEN_BITS    = 9;
    localparam int THR_BITS     = 16;
    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN    = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_AVG_THRESHOLD = 1'b1;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 9'd3;
    localparam logic [THR_BITS-1:0]  THR_RESET  = 16'd0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    typedef struct packed {
        logic evict;
        logic wfull;
        logic last;
    } t_ctrl;

endpackage

FILE: rtl/mwatc_front.sv
// ----------------------------------------------------------------------------
// mwatc_front
// Sample ring, write pointer and fill level; reads the sample leaving the window.
// ----------------------------------------------------------------------------
module mwatc_front #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int K_BITS      = 9,
    parameter int PTR_BITS    = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_seq_clr,
    input  logic [K_BITS-1:0]      i_k,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_seq_end,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic [SAMPLE_BITS-1:0] o_old,
    output mwatc_pkg::t_ctrl       o_ctrl
);

    localparam int AW = K_BITS + 1;

    logic [SAMPLE_BITS-1:0] r_ring [MAX_WINDOW];
    logic [PTR_BITS-1:0]    r_ptr;
    logic [PTR_BITS-1:0]    n_ptr;
    logic [K_BITS-1:0]      r_fill;
    logic [K_BITS-1:0]      n_fill;
    logic                   r_valid;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] r_old;
    mwatc_pkg::t_ctrl       r_ctrl;
    mwatc_pkg::t_ctrl       n_ctrl;
    logic [AW-1:0]          rd_wide;
    logic [PTR_BITS-1:0]    rd_addr;
    logic [PTR_BITS-1:0]    ptr_inc;
    logic [K_BITS-1:0]      fill_inc;

    always_comb begin
        rd_wide = AW'(r_ptr) + AW'(MAX_WINDOW) - AW'(i_k);
        if (rd_wide >= AW'(MAX_WINDOW)) begin
            rd_wide = rd_wide - AW'(MAX_WINDOW);
        end
        rd_addr = rd_wide[PTR_BITS-1:0];
        if (AW'(r_ptr) == AW'(MAX_WINDOW - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = r_ptr + PTR_BITS'(1);
        end
        fill_inc = r_fill + K_BITS'(1);
        n_ctrl.evict = (r_fill >= i_k);
        n_fill = n_ctrl.evict ? r_fill : fill_inc;
        n_ctrl.wfull = (n_fill == i_k);
        n_ctrl.last  = i_seq_end;
        if (i_seq_end) begin
            n_ptr = '0;
        end else begin
            n_ptr = ptr_inc;
        end
    end

    // read first: the oldest sample leaves before the new one lands
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_old         <= r_ring[rd_addr];
            r_ring[r_ptr] <= i_sample;
            r_sample      <= i_sample;
            r_ctrl        <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
            if (i_seq_clr) begin
                r_ptr  <= '0;
                r_fill <= '0;
            end else if (i_accept) begin
                r_ptr  <= n_ptr;
                r_fill <= i_seq_end ? '0 : n_fill;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;
    assign o_old    = r_old;
    assign o_ctrl   = r_ctrl;

endmodule

FILE: rtl/mwatc_queue.sv
// ----------------------------------------------------------------------------
// mwatc_queue
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module mwatc_queue #(
    parameter int WIDTH = 35
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr,
    input  logic [WIDTH-1:0]                     i_data,
    input  logic                                 i_rd,
    output logic [WIDTH-1:0]                     o_data,
    output logic                                 o_empty,
    output logic [mwatc_pkg::QUEUE_CNT_BITS-1:0] o_count
);

    logic [WIDTH-1:0]                     r_mem [mwatc_pkg::QUEUE_DEPTH];
    logic [mwatc_pkg::QUEUE_PTR_BITS-1:0] r_wptr;
    logic [mwatc_pkg::QUEUE_PTR_BITS-1:0] r_rptr;
    logic [mwatc_pkg::QUEUE_CNT_BITS-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + mwatc_pkg::QUEUE_PTR_BITS'(1);
            end
            if (i_rd) begin
                r_rptr <= r_rptr + mwatc_pkg::QUEUE_PTR_BITS'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + mwatc_pkg::QUEUE_CNT_BITS'(1);
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - mwatc_pkg::QUEUE_CNT_BITS'(1);
            end
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

FILE: rtl/mwatc_back.sv
// ----------------------------------------------------------------------------
// mwatc_back
// Window sum, threshold test, saturating count and result register.
// ----------------------------------------------------------------------------
module mwatc_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 20,
    parameter int SUM_BITS    = 25,
    parameter int NEED_BITS   = 25
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_seq_clr,
    input  logic [NEED_BITS-1:0]   i_need,
    input  logic                   i_q_empty,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_old,
    input  mwatc_pkg::t_ctrl       i_ctrl,
    output logic                   o_q_rd,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic                   o_window_ok,
    output logic [COUNT_BITS-1:0]  o_match_count,
    output logic                   o_count_final
);

    localparam int CMP_BITS = (SUM_BITS > NEED_BITS) ? SUM_BITS : NEED_BITS;

    logic [SUM_BITS-1:0]   r_sum;
    logic [SUM_BITS-1:0]   n_sum;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic                  r_out_valid;
    logic                  r_ok;
    logic [COUNT_BITS-1:0] r_match;
    logic                  r_final;
    logic                  take;
    logic                  ok;

    assign take = !i_q_empty && (!r_out_valid || i_pop);

    always_comb begin
        n_sum = r_sum + SUM_BITS'(i_sample);
        if (i_ctrl.evict) begin
            n_sum = n_sum - SUM_BITS'(i_old);
        end
        ok = i_ctrl.wfull && (CMP_BITS'(n_sum) >= CMP_BITS'(i_need));
        n_count = r_count;
        if (ok && !(&r_count)) begin
            n_count = r_count + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ok    <= ok;
            r_match <= n_count;
            r_final <= i_ctrl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (i_seq_clr) begin
                r_sum   <= '0;
                r_count <= '0;
            end else if (take) begin
                r_sum   <= i_ctrl.last ? '0 : n_sum;
                r_count <= i_ctrl.last ? '0 : n_count;
            end
        end
    end

    assign o_q_rd        = take;
    assign o_empty       = !r_out_valid;
    assign o_window_ok   = r_ok;
    assign o_match_count = r_match;
    assign o_count_final = r_final;

endmodule

FILE: rtl/moving_window_average_threshold_count_top.sv
// ----------------------------------------------------------------------------
// moving_window_average_threshold_count_top
// Sliding window sum over unsigned samples, counts windows whose average
// reaches a threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_sample and i_seq_end with push; a beat is taken
//   at an edge where push is high and full is low.
//   Result queue: while empty is low the oldest result sits on o_window_ok,
//   o_match_count and o_count_final; pop takes it.
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 = window_len, 1 = avg_threshold); a window_len write starts a new
//   sequence. Write only while the block is idle.
// Timing:
//   One beat per cycle sustained while full stays low. A taken beat is
//   read from the ring into the front register, then written into the
//   queue, then run through the sum update into the result register.
//   A stalled result holds while the front keeps taking beats until the
//   queue and the front stage hold four beats, then full rises.
// Reset: clears pointers, fill, sum, count and queues; window_len = 3,
//   avg_threshold = 0. Ring contents are not cleared.
// ----------------------------------------------------------------------------
module moving_window_average_threshold_count_top #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    input  logic                                i_seq_end,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_window_ok,
    output logic [COUNT_BITS-1:0]               o_match_count,
    output logic                                o_count_final,
    input  logic                                i_cfg_we,
    input  logic [mwatc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mwatc_pkg::CFG_BITS-1:0]      i_cfg_data
);

    localparam int K_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int PTR_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_BITS  = SAMPLE_BITS + K_BITS;
    localparam int NEED_BITS = K_BITS + mwatc_pkg::THR_BITS;
    localparam int CTRL_BITS = $bits(mwatc_pkg::t_ctrl);
    localparam int Q_BITS    = 2 * SAMPLE_BITS + CTRL_BITS;

    logic [mwatc_pkg::WLEN_BITS-1:0] r_wlen;
    logic [mwatc_pkg::THR_BITS-1:0]  r_thr;
    logic [NEED_BITS-1:0]            r_need;
    logic [K_BITS-1:0]               k_eff;
    logic                            seq_clr;
    logic                            accept;

    logic                                 f_valid;
    logic [SAMPLE_BITS-1:0]               f_sample;
    logic [SAMPLE_BITS-1:0]               f_old;
    mwatc_pkg::t_ctrl                     f_ctrl;
    logic [Q_BITS-1:0]                    q_head;
    logic                                 q_empty;
    logic                                 q_rd;
    logic [mwatc_pkg::QUEUE_CNT_BITS-1:0] q_count;
    mwatc_pkg::t_ctrl                     b_ctrl;

    assign seq_clr = i_cfg_we && (i_cfg_idx == mwatc_pkg::REG_WINDOW_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= mwatc_pkg::WLEN_RESET;
            r_thr  <= mwatc_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mwatc_pkg::REG_WINDOW_LEN: begin
                    r_wlen <= i_cfg_data[mwatc_pkg::WLEN_BITS-1:0];
                end
                mwatc_pkg::REG_AVG_THRESHOLD: begin
                    r_thr <= i_cfg_data[mwatc_pkg::THR_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_wlen == '0) begin
            k_eff = K_BITS'(1);
        end else if (32'(r_wlen) > MAX_WINDOW) begin
            k_eff = K_BITS'(MAX_WINDOW);
        end else begin
            k_eff = K_BITS'(r_wlen);
        end
    end

    always_ff @(posedge i_clk) begin
        r_need <= NEED_BITS'(k_eff) * NEED_BITS'(r_thr);
    end

    // hold off while the queue could not absorb the beat in flight
    assign full   = (32'(q_count) + 32'(f_valid)) >= mwatc_pkg::QUEUE_DEPTH;
    assign accept = push && !full;

    mwatc_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .K_BITS      (K_BITS),
        .PTR_BITS    (PTR_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_seq_clr (seq_clr),
        .i_k       (k_eff),
        .i_sample  (i_sample),
        .i_seq_end (i_seq_end),
        .o_valid   (f_valid),
        .o_sample  (f_sample),
        .o_old     (f_old),
        .o_ctrl    (f_ctrl)
    );

    mwatc_queue #(
        .WIDTH (Q_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_data  ({f_old, f_sample, f_ctrl}),
        .i_rd    (q_rd),
        .o_data  (q_head),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign b_ctrl = q_head[CTRL_BITS-1:0];

    mwatc_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .SUM_BITS    (SUM_BITS),
        .NEED_BITS   (NEED_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seq_clr     (seq_clr),
        .i_need        (r_need),
        .i_q_empty     (q_empty),
        .i_sample      (q_head[CTRL_BITS +: SAMPLE_BITS]),
        .i_old         (q_head[CTRL_BITS + SAMPLE_BITS +: SAMPLE_BITS]),
        .i_ctrl        (b_ctrl),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_window_ok   (o_window_ok),
        .o_match_count (o_match_count),
        .o_count_final (o_count_final)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window threshold counter. A scoreboard
// predicts window_ok, match_count and count_final for every sample beat taken
// and checks each popped result in order. Stimulus: a short directed set,
// then a fixed list of window lengths plus one random one, with random
// threshold settings, bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic        window_ok;
        logic [19:0] match_count;
        logic        count_final;
    } t_window_result;

    class window_scoreboard;
        logic [15:0]    ring [256];
        logic [7:0]     wr_ptr;
        logic [8:0]     fill;
        logic [23:0]    wsum;
        logic [19:0]    hits;
        logic [8:0]     wlen;
        logic [15:0]    thr;
        t_window_result expected_q[$];
        int             errors;

        function new();
            wlen   = mwatc_pkg::WLEN_RESET;
            thr    = mwatc_pkg::THR_RESET;
            errors = 0;
            restart();
        endfunction

        function void restart();
            wr_ptr = '0;
            fill   = '0;
            wsum   = '0;
            hits   = '0;
        endfunction

        function void write_reg(logic [mwatc_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [mwatc_pkg::CFG_BITS-1:0] data);
            if (idx == mwatc_pkg::REG_WINDOW_LEN) begin
                wlen = data[mwatc_pkg::WLEN_BITS-1:0];
                restart();
            end else if (idx == mwatc_pkg::REG_AVG_THRESHOLD) begin
                thr = data[mwatc_pkg::THR_BITS-1:0];
            end
        endfunction

        function void note_sample(logic [15:0] smp, logic last);
            logic [8:0]     k;
            logic [7:0]     old_idx;
            t_window_result r;
            k = (wlen == 9'd0) ? 9'd1 : (wlen > 9'd256) ? 9'd256 : wlen;
            if (fill >= k) begin
                old_idx = wr_ptr - k[7:0];
                wsum = wsum - 24'(ring[old_idx]);
            end
            ring[wr_ptr] = smp;
            wsum = wsum + 24'(smp);
            wr_ptr = wr_ptr + 8'd1;
            if (fill < k)
                fill = fill + 9'd1;
            r.window_ok = 1'b0;
            if (fill == k) begin
                r.window_ok = (32'(wsum) >= 32'(k) * 32'(thr));
                if (r.window_ok && hits != '1)
                    hits = hits + 20'd1;
            end
            r.match_count = hits;
            r.count_final = last;
            expected_q.push_back(r);
            if (last)
                restart();
        endfunction

        function void check_result(logic ok, logic [19:0] cnt, logic fin);
            t_window_result e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result ok=%0d count=%0d final=%0d",
                             $time, ok, cnt, fin);
                return;
            end
            e = expected_q.pop_front();
            if (ok !== e.window_ok || cnt !== e.match_count || fin !== e.count_final) begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: mismatch exp ok=%0d count=%0d final=%0d,",
                              " got ok=%0d count=%0d final=%0d"},
                             $time, e.window_ok, e.match_count, e.count_final,
                             ok, cnt, fin);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    localparam logic [12*9-1:0] PHASE_LENS = {9'd33, 9'd4, 9'd511, 9'd7, 9'd16, 9'd0,
                                              9'd8, 9'd256, 9'd5, 9'd3, 9'd2, 9'd1};

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                push;
    logic                                full;
    logic [15:0]                         i_sample;
    logic                                i_seq_end;
    logic                                empty;
    logic                                pop;
    logic                                o_window_ok;
    logic [19:0]                         o_match_count;
    logic                                o_count_final;
    logic                                i_cfg_we;
    logic [mwatc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [mwatc_pkg::CFG_BITS-1:0]      i_cfg_data;

    logic                                rx_stall;
    int                                  rx_left;
    window_scoreboard                    sb;

    moving_window_average_threshold_count_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_sample      (i_sample),
        .i_seq_end     (i_seq_end),
        .empty         (empty),
        .pop           (pop),
        .o_window_ok   (o_window_ok),
        .o_match_count (o_match_count),
        .o_count_final (o_count_final),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall <= 1'b0;
            rx_left  <= 0;
            pop      <= 1'b0;
        end else begin
            if (rx_left > 0) begin
                rx_left <= rx_left - 1;
            end else if (rx_stall) begin
                rx_stall <= 1'b0;
                rx_left  <= ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
            end else begin
                rx_stall <= 1'b1;
                rx_left  <= $urandom_range(1, 6);
            end
            pop <= !rx_stall;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_idx, i_cfg_data);
            if (push && !full)
                sb.note_sample(i_sample, i_seq_end);
            if (pop && !empty)
                sb.check_result(o_window_ok, o_match_count, o_count_final);
        end
    end

    task automatic send_beat(input logic [15:0] smp, input logic last);
        i_sample  <= smp;
        i_seq_end <= last;
        push      <= 1'b1;
        do @(posedge i_clk); while (full);
    endtask

    task automatic idle(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // hold off until every expected beat has come back
    task automatic drain();
        idle(1);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mwatc_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [mwatc_pkg::CFG_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int          wlen_eff;
        int          beats;
        int          seq_left;
        int          thr;
        int          spread;
        int          lo;
        int          hi;
        int          gap;
        int          burst_left;
        logic [8:0]  wlen;
        logic [15:0] smp;

        sb         = new();
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_sample   = '0;
        i_seq_end  = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = mwatc_pkg::REG_WINDOW_LEN;
        i_cfg_data = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h0000, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h0000, 1'b1);
        send_beat(16'hAAAA, 1'b0);
        send_beat(16'h5555, 1'b1);
        drain();
        write_reg(mwatc_pkg::REG_AVG_THRESHOLD, 16'hFFFF);
        write_reg(mwatc_pkg::REG_WINDOW_LEN, 16'hFE00);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'hFFFE, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        drain();
        write_reg(mwatc_pkg::REG_AVG_THRESHOLD, 16'h8000);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h7FFF, 1'b0);
        drain();
        write_reg(mwatc_pkg::REG_WINDOW_LEN, 16'hFE00);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h0000, 1'b1);
        drain();
        write_reg(mwatc_pkg::REG_WINDOW_LEN, 16'd2);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h0001, 1'b0);
        send_beat(16'h0000, 1'b0);
        send_beat(16'hFFFF, 1'b1);

        burst_left = 0;
        thr        = 0;
        spread     = 0;
        for (int p = 0; p < 13; p++) begin
            wlen     = (p == 12) ? 9'($urandom_range(9, 40)) : PHASE_LENS[p*9 +: 9];
            wlen_eff = (wlen == 9'd0) ? 1 : (wlen > 9'd256) ? 256 : int'(wlen);
            drain();
            write_reg(mwatc_pkg::REG_WINDOW_LEN, {7'($urandom), wlen});
            beats    = (wlen_eff >= 200) ? 320 : 60;
            seq_left = 0;
            for (int n = 0; n < beats; n++) begin
                if (n == 0 || n == beats / 2) begin
                    if (n != 0)
                        drain();
                    case ($urandom_range(0, 5))
                        0:       thr = 0;
                        1:       thr = 65535;
                        default: thr = $urandom_range(0, 65535);
                    endcase
                    spread = $urandom_range(0, 4096);
                    write_reg(mwatc_pkg::REG_AVG_THRESHOLD, 16'(thr));
                end
                if (seq_left == 0)
                    seq_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, wlen_eff)
                                                           : wlen_eff + $urandom_range(0, 40);
                seq_left--;
                case ($urandom_range(0, 15))
                    0:       smp = 16'h0000;
                    1:       smp = 16'hFFFF;
                    default: begin
                        lo = thr - spread;
                        hi = thr + spread;
                        if (lo < 0)
                            lo = 0;
                        if (hi > 65535)
                            hi = 65535;
                        smp = 16'($urandom_range(lo, hi));
                    end
                endcase
                if (burst_left == 0) begin
                    gap = $urandom_range(0, 5);
                    if (gap != 0)
                        idle(gap);
                    burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
                end
                burst_left--;
                send_beat(smp, seq_left == 0);
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
